@@ design/v4alu_pkg.sv @@
// Package for the four-lane Q16.16 vector unit: widths, opcodes, item and pipeline types.
// Also holds the shared saturation function.
// No dependencies; every module of the block imports it.
package v4alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;

  localparam int PROD_W    = 2 * WORD_BITS;            // exact lane product magnitude
  localparam int SUM_W     = PROD_W + 2;               // signed sum of four products
  localparam int MAG_W     = SUM_W - 1 - FRAC_BITS;    // magnitude width into saturation
  localparam int ROOT_W    = PROD_W / 2 + 1;           // floor root of the sum
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_STAGES = ROOT_W;                   // one root bit per stage
  localparam int QUO_W     = WORD_BITS + FRAC_BITS;    // scaled quotient width
  localparam int DIV_STAGES = QUO_W;                   // one quotient bit per stage
  localparam int DEN_W     = ROOT_W;
  localparam int PIPE_DEPTH = 3 + SQ_STAGES + DIV_STAGES;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [MAG_W-1:0]     HALF_MAG = {{(MAG_W-WORD_BITS){1'b0}}, WORD_MIN};

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_SADD  = 4'd4,
    OP_SSUB  = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SDIV  = 4'd7,
    OP_VEQ   = 4'd8,
    OP_SEQ   = 4'd9,
    OP_DOT   = 4'd10,
    OP_MAGSQ = 4'd11,
    OP_MAG   = 4'd12,
    OP_NORM  = 4'd13,
    OP_NEG   = 4'd14
  } op_e;

  typedef struct packed {
    logic [3:0]                  opcode;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] a_w;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] b_w;
    logic signed [WORD_BITS-1:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_w;
    logic signed [WORD_BITS-1:0] scalar_out;
    logic                        equal_flag;
    logic                        div_zero;
    logic                        overflow;
  } out_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] w;
    logic                 ov;
  } sat_t;

  // Operand magnitudes and signs that the divide stage needs later.
  typedef struct packed {
    logic [WORD_BITS-1:0] amag;
    logic                 aneg;
    logic [WORD_BITS-1:0] ymag;
    logic                 yneg;
    logic                 yzero;
  } opnd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] w;
    logic                 ov;
    logic                 eq;
    logic [PROD_W-1:0]    prod;
    logic                 pneg;
    opnd_t                opnd;
  } lane_t;

  typedef struct packed {
    logic [LANES-1:0][WORD_BITS-1:0] r;
    logic [WORD_BITS-1:0]            so;
    logic                            eq;
    logic                            dz;
    logic                            ov;
    logic [LANES-1:0]                run;
    logic [LANES-1:0]                qneg;
  } res_t;

  typedef struct packed {
    op_e                    op;
    logic                   nz;
    res_t                   res;
    opnd_t [LANES-1:0]      opnd;
  } ctx_t;

  // Clamp a magnitude with sign to the signed word range.
  function automatic sat_t sat_mag(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0]     lim;
    logic [WORD_BITS-1:0] m;
    sat_t                 r;
    lim  = neg ? HALF_MAG : HALF_MAG - 1'b1;
    r.ov = mag > lim;
    m    = r.ov ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
    r.w  = neg ? (~m + 1'b1) : m;
    return r;
  endfunction

endpackage

@@ design/v4alu_lane.sv @@
// One vector lane: operand decode, saturating add/sub/negate, equality and exact product.
// Depends on v4alu_pkg.
module v4alu_lane import v4alu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  op_e                  op_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] y_i,
  output lane_t                lane_o
);

  logic                 a_neg, y_neg, is_sub, sum_ov, neg_ov;
  logic [WORD_BITS-1:0] a_mag, y_mag, sum_w, neg_w;
  logic [WORD_BITS+1:0] a_ext, y_ext, sum;
  lane_t                lane_d, lane_q;

  always_comb begin
    a_neg  = a_i[WORD_BITS-1];
    y_neg  = y_i[WORD_BITS-1];
    a_mag  = a_neg ? (~a_i + 1'b1) : a_i;
    y_mag  = y_neg ? (~y_i + 1'b1) : y_i;
    a_ext  = {{2{a_neg}}, a_i};
    y_ext  = {{2{y_neg}}, y_i};
    is_sub = (op_i == OP_SUB) || (op_i == OP_SSUB);
    sum    = is_sub ? a_ext - y_ext : a_ext + y_ext;
    // out of range when the top three bits disagree
    sum_ov = (|sum[WORD_BITS+1:WORD_BITS-1]) && !(&sum[WORD_BITS+1:WORD_BITS-1]);
    sum_w  = sum_ov ? (sum[WORD_BITS+1] ? WORD_MIN : WORD_MAX) : sum[WORD_BITS-1:0];
    neg_ov = a_i == WORD_MIN;
    neg_w  = neg_ov ? WORD_MAX : (~a_i + 1'b1);

    lane_d.w  = '0;
    lane_d.ov = 1'b0;
    case (op_i)
      OP_ADD, OP_SUB, OP_SADD, OP_SSUB: begin
        lane_d.w  = sum_w;
        lane_d.ov = sum_ov;
      end
      OP_NEG: begin
        lane_d.w  = neg_w;
        lane_d.ov = neg_ov;
      end
      default: begin
        lane_d.w  = '0;
        lane_d.ov = 1'b0;
      end
    endcase
    lane_d.eq         = a_i == y_i;
    lane_d.prod       = a_mag * y_mag;
    lane_d.pneg       = a_neg ^ y_neg;
    lane_d.opnd.amag  = a_mag;
    lane_d.opnd.aneg  = a_neg;
    lane_d.opnd.ymag  = y_mag;
    lane_d.opnd.yneg  = y_neg;
    lane_d.opnd.yzero = y_i == '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

@@ design/v4alu_merge.sv @@
// Merge stage: sums the four lane products, saturates lane products and the dot sum,
// and builds the per-item context. Two register stages. Depends on v4alu_pkg.
module v4alu_merge import v4alu_pkg::*; (
  input  logic                clk_i,
  input  logic                adv_i,
  input  op_e                 op_i,
  input  lane_t [LANES-1:0]   lanes_i,
  output ctx_t                ctx_o,
  output logic [RAD_W-1:0]    rad_o
);

  logic [PROD_W:0]           ps [LANES];
  logic [SUM_W-1:0]          s01_d, s23_d, s01_q, s23_q;
  sat_t [LANES-1:0]          msat_d, msat_q;
  lane_t [LANES-1:0]         lanes_q;
  op_e                       op_q;

  logic [SUM_W-1:0]          acc, acc_abs;
  logic                      acc_neg;
  logic [SUM_W-2:0]          acc_mag;
  sat_t                      dsat;
  ctx_t                      ctx_d, ctx_q;
  logic [RAD_W-1:0]          rad_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ps[i] = lanes_i[i].pneg ? (~{1'b0, lanes_i[i].prod} + 1'b1) : {1'b0, lanes_i[i].prod};
      msat_d[i] = sat_mag(MAG_W'(lanes_i[i].prod[PROD_W-1:FRAC_BITS]), lanes_i[i].pneg);
    end
    s01_d = {ps[0][PROD_W], ps[0]} + {ps[1][PROD_W], ps[1]};
    s23_d = {ps[2][PROD_W], ps[2]} + {ps[3][PROD_W], ps[3]};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s01_q   <= s01_d;
      s23_q   <= s23_d;
      msat_q  <= msat_d;
      lanes_q <= lanes_i;
      op_q    <= op_i;
    end
  end

  always_comb begin
    acc     = s01_q + s23_q;
    acc_neg = acc[SUM_W-1];
    acc_abs = acc_neg ? (~acc + 1'b1) : acc;
    acc_mag = acc_abs[SUM_W-2:0];
    dsat    = sat_mag(acc_mag[SUM_W-2:FRAC_BITS], acc_neg);

    ctx_d     = '0;
    ctx_d.op  = op_q;
    for (int i = 0; i < LANES; i++) begin
      ctx_d.opnd[i] = lanes_q[i].opnd;
      ctx_d.nz      = ctx_d.nz | (lanes_q[i].opnd.amag != '0);
    end
    case (op_q)
      OP_ADD, OP_SUB, OP_SADD, OP_SSUB, OP_NEG: begin
        for (int i = 0; i < LANES; i++) begin
          ctx_d.res.r[i] = lanes_q[i].w;
          ctx_d.res.ov   = ctx_d.res.ov | lanes_q[i].ov;
        end
      end
      OP_MUL, OP_SMUL: begin
        for (int i = 0; i < LANES; i++) begin
          ctx_d.res.r[i] = msat_q[i].w;
          ctx_d.res.ov   = ctx_d.res.ov | msat_q[i].ov;
        end
      end
      OP_VEQ, OP_SEQ: begin
        ctx_d.res.eq = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          ctx_d.res.eq = ctx_d.res.eq & lanes_q[i].eq;
        end
      end
      OP_DOT, OP_MAGSQ: begin
        ctx_d.res.so = dsat.w;
        ctx_d.res.ov = dsat.ov;
      end
      default: begin
        ctx_d.res.ov = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctx_q <= ctx_d;
      rad_q <= {1'b0, acc_mag};
    end
  end

  assign ctx_o = ctx_q;
  assign rad_o = rad_q;

endmodule

@@ design/v4alu_sqrt.sv @@
// Pipelined floor square root of the product sum, one root bit per stage.
// Carries the item context alongside. Depends on v4alu_pkg.
module v4alu_sqrt import v4alu_pkg::*; (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [RAD_W-1:0]   rad_i,
  input  ctx_t               ctx_i,
  output logic [ROOT_W-1:0]  root_o,
  output ctx_t               ctx_o
);

  logic [REM_W-1:0]  rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQ_STAGES];
  ctx_t              ctx_q  [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam int K = SQ_STAGES - 1 - s;
    logic [REM_W-1:0]  prev_rem, rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] prev_root, root_d;
    logic [RAD_W-1:0]  prev_rad;
    ctx_t              prev_ctx;

    if (s == 0) begin : g_first
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_rad  = rad_i;
      assign prev_ctx  = ctx_i;
    end else begin : g_next
      assign prev_rem  = rem_q[s-1];
      assign prev_root = root_q[s-1];
      assign prev_rad  = rad_q[s-1];
      assign prev_ctx  = ctx_q[s-1];
    end

    always_comb begin
      rem_sh = {prev_rem[REM_W-3:0], prev_rad[2*K+1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, prev_root, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {prev_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {prev_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= prev_rad;
        ctx_q[s]  <= prev_ctx;
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];
  assign ctx_o  = ctx_q[SQ_STAGES-1];

endmodule

@@ design/v4alu_div.sv @@
// Pipelined restoring divider for one lane: floor(num * 2^FRAC_BITS / den),
// one quotient bit per stage. Depends on v4alu_pkg.
module v4alu_div import v4alu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic [WORD_BITS-1:0] num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic [QUO_W-1:0]     quo_o
);

  logic [DEN_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [QUO_W-1:0] num_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int I = QUO_W - 1 - s;
    logic [DEN_W-1:0] prev_rem, prev_den, rem_d;
    logic [QUO_W-1:0] prev_quo, prev_num;
    logic [DEN_W:0]   sh, den_ext, diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_quo = '0;
      assign prev_num = {num_i, {FRAC_BITS{1'b0}}};
      assign prev_den = den_i;
    end else begin : g_next
      assign prev_rem = rem_q[s-1];
      assign prev_quo = quo_q[s-1];
      assign prev_num = num_q[s-1];
      assign prev_den = den_q[s-1];
    end

    always_comb begin
      sh      = {prev_rem, prev_num[I]};
      den_ext = {1'b0, prev_den};
      diff    = sh - den_ext;
      ge      = sh >= den_ext;
      rem_d   = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= {prev_quo[QUO_W-2:0], ge};
        num_q[s] <= prev_num;
        den_q[s] <= prev_den;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

@@ design/vec4_alu_top.sv @@
// Top level of the four-component Q16.16 vector unit: lanes, merge, square root,
// per-lane dividers and the output register. Depends on v4alu_pkg and all v4alu_* modules.
//
// Fully pipelined: one item is accepted per cycle while the output is not stalled. Its
// result passes one lane stage, two merge stages, 33 square-root stages with one root bit
// each, 48 divider stages with one quotient bit each, and then the output register.
// Every opcode takes the same path, so results leave in order. A stall on a valid output
// item freezes the whole pipeline, and the input is stalled in the same cycle.
module vec4_alu_top import v4alu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic                            adv;
  op_e                             in_op, op1_q;
  logic [LANES-1:0][WORD_BITS-1:0] a_vec, b_vec, y_vec;
  lane_t [LANES-1:0]               lane_q;
  ctx_t                            ctx_m, ctx_s;
  logic [RAD_W-1:0]                rad_m;
  logic [ROOT_W-1:0]               root_s;
  res_t                            res_p;
  logic [LANES-1:0][DEN_W-1:0]     den_p;
  sat_t                            msat;
  logic [LANES-1:0][QUO_W-1:0]     quo;
  res_t                            res_q [DIV_STAGES];
  res_t                            res_f;
  sat_t [LANES-1:0]                qsat;
  logic [PIPE_DEPTH-1:0]           vld_q;
  logic                            out_valid_q;
  out_item_t                       out_d, out_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign in_op       = op_e'(in_item_i.opcode);

  assign a_vec = {in_item_i.a_w, in_item_i.a_z, in_item_i.a_y, in_item_i.a_x};
  assign b_vec = {in_item_i.b_w, in_item_i.b_z, in_item_i.b_y, in_item_i.b_x};

  // pick the second operand of each lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      case (in_op)
        OP_SADD, OP_SSUB, OP_SMUL, OP_SDIV, OP_SEQ: y_vec[i] = in_item_i.scalar_in;
        OP_MAGSQ, OP_MAG, OP_NORM:                  y_vec[i] = a_vec[i];
        default:                                    y_vec[i] = b_vec[i];
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    v4alu_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .op_i   (in_op),
      .a_i    (a_vec[g]),
      .y_i    (y_vec[g]),
      .lane_o (lane_q[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= in_op;
    end
  end

  v4alu_merge u_merge (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .op_i    (op1_q),
    .lanes_i (lane_q),
    .ctx_o   (ctx_m),
    .rad_o   (rad_m)
  );

  v4alu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .rad_i  (rad_m),
    .ctx_i  (ctx_m),
    .root_o (root_s),
    .ctx_o  (ctx_s)
  );

  // set up the divide: lane divisor, quotient sign, zero-divisor lanes, magnitude
  always_comb begin
    res_p = ctx_s.res;
    msat  = sat_mag(MAG_W'(root_s), 1'b0);
    for (int i = 0; i < LANES; i++) begin
      den_p[i] = {1'b0, ctx_s.opnd[i].ymag};
    end
    case (ctx_s.op)
      OP_DIV, OP_SDIV: begin
        for (int i = 0; i < LANES; i++) begin
          if (ctx_s.opnd[i].yzero) begin
            res_p.r[i] = WORD_MAX;
            res_p.dz   = 1'b1;
          end else begin
            res_p.run[i]  = 1'b1;
            res_p.qneg[i] = ctx_s.opnd[i].aneg ^ ctx_s.opnd[i].yneg;
          end
        end
      end
      OP_MAG: begin
        res_p.so = msat.w;
        res_p.ov = msat.ov;
      end
      OP_NORM: begin
        for (int i = 0; i < LANES; i++) begin
          res_p.run[i]  = ctx_s.nz;
          res_p.qneg[i] = ctx_s.opnd[i].aneg;
          den_p[i]      = root_s;
        end
      end
      default: begin
        res_p.run = '0;
      end
    endcase
  end

  for (genvar g = 0; g < LANES; g++) begin : g_div
    v4alu_div u_div (
      .clk_i (clk_i),
      .adv_i (adv),
      .num_i (ctx_s.opnd[g].amag),
      .den_i (den_p[g]),
      .quo_o (quo[g])
    );
  end

  // hold the partial result beside the dividers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q[0] <= res_p;
      for (int s = 1; s < DIV_STAGES; s++) begin
        res_q[s] <= res_q[s-1];
      end
    end
  end

  always_comb begin
    res_f = res_q[DIV_STAGES-1];
    for (int i = 0; i < LANES; i++) begin
      qsat[i] = sat_mag(MAG_W'(quo[i]), res_f.qneg[i]);
      if (res_f.run[i]) begin
        res_f.r[i] = qsat[i].w;
        res_f.ov   = res_f.ov | qsat[i].ov;
      end
    end
    out_d.r_x        = res_f.r[0];
    out_d.r_y        = res_f.r[1];
    out_d.r_z        = res_f.r[2];
    out_d.r_w        = res_f.r[3];
    out_d.scalar_out = res_f.so;
    out_d.equal_flag = res_f.eq;
    out_d.div_zero   = res_f.dz;
    out_d.overflow   = res_f.ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
      out_valid_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // a stalled result freezes every stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vld_q))
    else $error("pipeline moved while the output item was stalled");

  a_eq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.equal_flag |-> !out_item_o.div_zero && !out_item_o.overflow)
    else $error("compare item carries arithmetic flags");

  a_dz_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.div_zero |-> out_item_o.scalar_out == '0)
    else $error("divide item carries a scalar result");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[PIPE_DEPTH-1]))
    else $error("output item appeared without a pipeline item");

endmodule
